FILE: rtl/core/fdc_pkg.sv
package fdc_pkg;

  localparam int QueueDepth = 16;
  localparam int IdBits     = 16;
  localparam int ClassBits  = 2;
  localparam int IdxBits    = $clog2(QueueDepth);
  localparam int CntBits    = $clog2(QueueDepth + 1);

  localparam int InDataBits  = ((IdBits + ClassBits + 7) / 8) * 8;
  localparam int OutRawBits  = 1 + IdBits + CntBits + 1 + 1 + IdBits;
  localparam int OutDataBits = ((OutRawBits + 7) / 8) * 8;

  typedef enum logic {
    CmdAppend = 1'b0,
    CmdRemove = 1'b1
  } cmd_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic commit;
  } fdc_ctrl_t;

  typedef struct packed {
    logic                 ok;
    logic [IdBits-1:0]    removed_id;
    logic [CntBits-1:0]   occupancy;
    logic                 is_empty;
    logic                 front_valid;
    logic [IdBits-1:0]    front_id;
  } fdc_result_t;

endpackage

FILE: rtl/core/fdc_ctrl.sv
module fdc_ctrl import fdc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output fdc_ctrl_t ctrl_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  // result register can take a new value when empty or being drained now
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d        = state_q;
    out_valid_d    = out_valid_q;
    ctrl_o.capture = 1'b0;
    ctrl_o.commit  = 1'b0;
    in_ready_o     = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.capture = 1'b1;
          state_d        = StExec;
        end
      end
      StExec: begin
        if (out_free) begin
          ctrl_o.commit = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/core/fdc_dpath.sv
module fdc_dpath import fdc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fdc_ctrl_t            ctrl_i,
  input  logic                 cmd_i,
  input  logic [IdBits-1:0]    entry_id_i,
  input  logic [ClassBits-1:0] entry_class_i,
  output fdc_result_t          result_o
);

  logic                 cmd_q;
  logic [IdBits-1:0]    id_q;
  logic [ClassBits-1:0] cls_q;

  logic [IdBits-1:0]    slot_id_q  [QueueDepth];
  logic [IdBits-1:0]    slot_id_d  [QueueDepth];
  logic [ClassBits-1:0] slot_cls_q [QueueDepth];
  logic [ClassBits-1:0] slot_cls_d [QueueDepth];
  logic [CntBits-1:0]   cnt_q, cnt_d;

  fdc_result_t          result_q, result_d;

  logic [QueueDepth-1:0] match;
  logic [QueueDepth-1:0] shift_en;
  logic [IdxBits-1:0]    sel_idx;
  logic                  found;
  logic                  full;
  logic                  do_append;
  logic                  do_remove;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q <= cmd_i;
      id_q  <= entry_id_i;
      cls_q <= entry_class_i;
    end
  end

  // per-slot class compare, limited to occupied slots
  always_comb begin
    for (int i = 0; i < QueueDepth; i++) begin
      match[i] = (CntBits'(i) < cnt_q) && (slot_cls_q[i] == cls_q);
    end
  end

  // oldest match wins
  always_comb begin
    sel_idx = '0;
    for (int i = QueueDepth - 1; i >= 0; i--) begin
      if (match[i]) begin
        sel_idx = IdxBits'(i);
      end
    end
  end

  // slots at and behind the removed one move up
  always_comb begin
    shift_en[0] = match[0];
    for (int i = 1; i < QueueDepth; i++) begin
      shift_en[i] = shift_en[i-1] | match[i];
    end
  end

  assign found     = |match;
  assign full      = (cnt_q == CntBits'(QueueDepth));
  assign do_append = (cmd_q == CmdAppend) && !full;
  assign do_remove = (cmd_q == CmdRemove) && found;

  always_comb begin
    for (int i = 0; i < QueueDepth; i++) begin
      slot_id_d[i]  = slot_id_q[i];
      slot_cls_d[i] = slot_cls_q[i];
      if (do_append && (CntBits'(i) == cnt_q)) begin
        slot_id_d[i]  = id_q;
        slot_cls_d[i] = cls_q;
      end else if (do_remove && shift_en[i] && (i < QueueDepth - 1)) begin
        slot_id_d[i]  = slot_id_q[(i + 1) % QueueDepth];
        slot_cls_d[i] = slot_cls_q[(i + 1) % QueueDepth];
      end
    end

    cnt_d = cnt_q;
    if (do_append) begin
      cnt_d = cnt_q + CntBits'(1);
    end else if (do_remove) begin
      cnt_d = cnt_q - CntBits'(1);
    end

    result_d.ok          = do_append || do_remove;
    result_d.removed_id  = do_remove ? slot_id_q[sel_idx] : '0;
    result_d.occupancy   = cnt_d;
    result_d.is_empty    = (cnt_d == '0);
    result_d.front_valid = (cnt_d != '0);
    result_d.front_id    = (cnt_d != '0) ? slot_id_d[0] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) begin
      for (int i = 0; i < QueueDepth; i++) begin
        slot_id_q[i]  <= slot_id_d[i];
        slot_cls_q[i] <= slot_cls_d[i];
      end
      result_q <= result_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctrl_i.commit) begin
      cnt_q <= cnt_d;
    end
  end

  assign result_o = result_q;

endmodule

FILE: rtl/core/fifo_dequeue_first_by_class_top.sv
// Ordered queue of 16 entries (16-bit id, 2-bit class). tuser 0 appends at
// the tail, tuser 1 removes the oldest entry whose class matches and closes
// the gap. Each transfer in gives one transfer out with ok, removed id,
// occupancy, empty flag and head entry. Idle captures a command; exec then
// does the parallel class compare, first-match select and slot shift once
// the output register is free. A new command is taken while the previous
// result still waits on the output register. Reset empties the queue.
module fifo_dequeue_first_by_class_top import fdc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // entry_id [15:0], entry_class [17:16], zero [23:18]
  input  logic [InDataBits-1:0]  s_axis_tdata,
  // cmd [0]
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // ok [0], removed_id [16:1], occupancy [21:17], is_empty [22],
  // front_valid [23], front_id [39:24]
  output logic [OutDataBits-1:0] m_axis_tdata
);

  fdc_ctrl_t   ctrl;
  fdc_result_t result;

  fdc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .ctrl_o      (ctrl)
  );

  fdc_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .cmd_i         (s_axis_tuser),
    .entry_id_i    (s_axis_tdata[IdBits-1:0]),
    .entry_class_i (s_axis_tdata[IdBits +: ClassBits]),
    .result_o      (result)
  );

  assign m_axis_tdata = OutDataBits'({result.front_id, result.front_valid, result.is_empty,
                                      result.occupancy, result.removed_id, result.ok});

endmodule
